FILE: hw/rtl/ght_pkg.sv
// Shared types, codes and default sizes for the generational handle table.
package ght_pkg;

    localparam int SLOTS_DEF       = 64;
    localparam int COLOR_SLOTS_DEF = 8;
    localparam int GEN_BITS_DEF    = 8;

    localparam int CMD_W      = 3;
    localparam int IDX_PORT_W = 6;
    localparam int GEN_PORT_W = 8;
    localparam int SIZE_W     = 16;
    localparam int CSEL_W     = 3;
    localparam int TEX_W      = 32;
    localparam int STATUS_W   = 2;

    localparam logic [TEX_W-1:0] NO_TEXTURE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_BIND   = 3'd2,
        CMD_ATTACH = 3'd3,
        CMD_DEPTH  = 3'd4,
        CMD_RESIZE = 3'd5,
        CMD_QCOLOR = 3'd6,
        CMD_QDEPTH = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_STALE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch request, issue memory reads
        logic commit;   // write back, load result register
    } ght_ctl_t;

endpackage

FILE: hw/rtl/ght_ctrl.sv
// Controller state machine: request acceptance, commit timing, result valid.
module ght_ctrl
    import ght_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output ght_ctl_t ctl
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.capture = 1'b0;
        ctl.commit  = 1'b0;
        in_stall    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                ctl.capture = in_valid;
            end
            S_EXEC:
            begin
                ctl.commit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/ght_datapath.sv
// Datapath: slot record memories, free queue, attachment stores, result register.
module ght_datapath
    import ght_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int COLOR_SLOTS = COLOR_SLOTS_DEF,
    parameter int GEN_BITS    = GEN_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ght_ctl_t              ctl,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [IDX_PORT_W-1:0] handle_index,
    input  logic [GEN_PORT_W-1:0] handle_gen,
    input  logic [SIZE_W-1:0]     new_width,
    input  logic [SIZE_W-1:0]     new_height,
    input  logic [CSEL_W-1:0]     color_slot,
    input  logic [TEX_W-1:0]      texture_word,
    output logic [STATUS_W-1:0]   status,
    output logic [IDX_PORT_W-1:0] out_index,
    output logic [GEN_PORT_W-1:0] out_gen,
    output logic [SIZE_W-1:0]     out_width,
    output logic [SIZE_W-1:0]     out_height,
    output logic                  needs_rebuild,
    output logic [TEX_W-1:0]      out_texture
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int AW     = (CNT_W > IDX_PORT_W) ? CNT_W : IDX_PORT_W;
    localparam int GW     = (GEN_BITS > GEN_PORT_W) ? GEN_BITS : GEN_PORT_W;
    localparam int CS_W   = (COLOR_SLOTS > 1) ? $clog2(COLOR_SLOTS) : 1;
    localparam int CDEPTH = SLOTS * (2 ** CS_W);
    localparam int MASK_W = COLOR_SLOTS + 1;
    localparam logic [MASK_W-1:0] DEPTH_BIT = MASK_W'(1) << COLOR_SLOTS;

    // memories
    logic [GEN_BITS-1:0] gen_mem   [SLOTS];
    logic [1:0]          flag_mem  [SLOTS];   // {live, dirty}
    logic [2*SIZE_W-1:0] size_mem  [SLOTS];   // {width, height}
    logic [MASK_W-1:0]   mask_mem  [SLOTS];
    logic [TEX_W-1:0]    depth_mem [SLOTS];
    logic [TEX_W-1:0]    color_mem [CDEPTH];
    logic [IDX_W-1:0]    fq_mem    [SLOTS];

    // control state
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] fresh_count_reg, fresh_count_next;

    // latched request and read data
    cmd_t                cmd_reg;
    logic [IDX_PORT_W-1:0] idx_reg;
    logic [GEN_PORT_W-1:0] hgen_reg;
    logic [SIZE_W-1:0]   nw_reg;
    logic [SIZE_W-1:0]   nh_reg;
    logic [CSEL_W-1:0]   cs_reg;
    logic [TEX_W-1:0]    tex_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic                full_reg;
    logic                fresh_pick_reg;
    logic [GEN_BITS-1:0] gen_rd_reg;
    logic [1:0]          flag_rd_reg;
    logic [2*SIZE_W-1:0] size_rd_reg;
    logic [MASK_W-1:0]   mask_rd_reg;
    logic [TEX_W-1:0]    depth_rd_reg;
    logic [TEX_W-1:0]    color_rd_reg;
    logic [IDX_W-1:0]    q_head_reg;

    // result register
    logic [STATUS_W-1:0]   status_reg;
    logic [IDX_PORT_W-1:0] out_index_reg;
    logic [GEN_PORT_W-1:0] out_gen_reg;
    logic [SIZE_W-1:0]     out_width_reg;
    logic [SIZE_W-1:0]     out_height_reg;
    logic                  needs_rebuild_reg;
    logic [TEX_W-1:0]      out_texture_reg;

    // capture-side signals
    logic             from_queue;
    logic             fresh_avail;
    logic [IDX_W-1:0] rd_slot;
    logic [CS_W-1:0]  cs_addr;

    // commit-side signals
    logic                gen_we, flag_we, size_we, mask_we, color_we, depth_we;
    logic [GEN_BITS-1:0] gen_wd, cur_gen;
    logic [1:0]          flag_wd;
    logic [MASK_W-1:0]   mask_wd, mask_shift;
    logic                pop, push, push_ok, bump_fresh;
    logic                handle_ok, gen_eq, cs_ok;
    logic [CNT_W:0]      tail_sum;
    logic [IDX_W-1:0]    tail, head_inc;
    status_t             res_status;
    logic [IDX_PORT_W-1:0] res_idx;
    logic [GEN_PORT_W-1:0] res_gen;
    logic [SIZE_W-1:0]   res_w, res_h;
    logic                res_mark;
    logic [TEX_W-1:0]    res_tex;

    assign from_queue  = (fill_reg != '0);
    assign fresh_avail = (fresh_count_reg < CNT_W'(SLOTS));
    assign cs_addr     = CS_W'(color_slot);

    always_comb
    begin
        if (cmd_t'(cmd) == CMD_CREATE)
        begin
            rd_slot = from_queue ? q_head_reg : IDX_W'(fresh_count_reg);
        end
        else
        begin
            rd_slot = IDX_W'(handle_index);
        end
    end

    // free queue pointers
    assign tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(fill_reg);
    assign tail     = (tail_sum >= (CNT_W+1)'(SLOTS)) ? IDX_W'(tail_sum - (CNT_W+1)'(SLOTS))
                                                      : IDX_W'(tail_sum);
    assign head_inc = (head_reg == IDX_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign push_ok  = ctl.commit && push && (fill_reg < CNT_W'(SLOTS));

    assign head_next = (ctl.commit && pop) ? head_inc : head_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.commit && pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
        else if (push_ok)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    assign fresh_count_next = (ctl.commit && bump_fresh) ? fresh_count_reg + 1'b1
                                                         : fresh_count_reg;

    // handle check
    assign gen_eq    = (GW'(gen_rd_reg) == GW'(hgen_reg));
    assign handle_ok = (AW'(idx_reg) < AW'(fresh_count_reg)) && flag_rd_reg[1] && gen_eq;
    assign cs_ok     = (5'(cs_reg) < 5'(COLOR_SLOTS));
    assign mask_shift = mask_rd_reg >> cs_reg;
    assign cur_gen   = fresh_pick_reg ? '0 : gen_rd_reg;

    always_comb
    begin
        gen_we     = 1'b0;
        gen_wd     = gen_rd_reg;
        flag_we    = 1'b0;
        flag_wd    = flag_rd_reg;
        size_we    = 1'b0;
        mask_we    = 1'b0;
        mask_wd    = mask_rd_reg;
        color_we   = 1'b0;
        depth_we   = 1'b0;
        pop        = 1'b0;
        push       = 1'b0;
        bump_fresh = 1'b0;
        res_status = ST_OK;
        res_idx    = idx_reg;
        res_gen    = hgen_reg;
        res_w      = '0;
        res_h      = '0;
        res_mark   = 1'b0;
        res_tex    = '0;
        if (cmd_reg == CMD_CREATE)
        begin
            if (full_reg)
            begin
                res_status = ST_FULL;
                res_idx    = '0;
                res_gen    = '0;
            end
            else
            begin
                // fresh slots get generation zero written so later reads are defined
                gen_we     = 1'b1;
                gen_wd     = cur_gen;
                flag_we    = 1'b1;
                flag_wd    = 2'b11;
                size_we    = 1'b1;
                mask_we    = 1'b1;
                mask_wd    = '0;
                pop        = !fresh_pick_reg;
                bump_fresh = fresh_pick_reg;
                res_idx    = IDX_PORT_W'(slot_reg);
                res_gen    = GEN_PORT_W'(cur_gen);
            end
        end
        else if (!handle_ok)
        begin
            res_status = ST_STALE;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_DELETE:
                begin
                    gen_we  = 1'b1;
                    gen_wd  = gen_rd_reg + 1'b1;
                    flag_we = 1'b1;
                    flag_wd = 2'b00;
                    push    = 1'b1;
                end
                CMD_BIND:
                begin
                    flag_we  = 1'b1;
                    flag_wd  = {flag_rd_reg[1], 1'b0};
                    res_w    = size_rd_reg[2*SIZE_W-1:SIZE_W];
                    res_h    = size_rd_reg[SIZE_W-1:0];
                    res_mark = flag_rd_reg[0];
                end
                CMD_ATTACH:
                begin
                    if (cs_ok)
                    begin
                        color_we = 1'b1;
                        mask_we  = 1'b1;
                        mask_wd  = mask_rd_reg | (MASK_W'(1) << cs_reg);
                        flag_we  = 1'b1;
                        flag_wd  = {flag_rd_reg[1], 1'b1};
                    end
                end
                CMD_DEPTH:
                begin
                    depth_we = 1'b1;
                    mask_we  = 1'b1;
                    mask_wd  = mask_rd_reg | DEPTH_BIT;
                    flag_we  = 1'b1;
                    flag_wd  = {flag_rd_reg[1], 1'b1};
                end
                CMD_RESIZE:
                begin
                    size_we = 1'b1;
                    flag_we = 1'b1;
                    flag_wd = {flag_rd_reg[1], 1'b1};
                end
                CMD_QCOLOR:
                begin
                    res_w    = size_rd_reg[2*SIZE_W-1:SIZE_W];
                    res_h    = size_rd_reg[SIZE_W-1:0];
                    res_mark = flag_rd_reg[0];
                    res_tex  = (cs_ok && mask_shift[0]) ? color_rd_reg : NO_TEXTURE;
                end
                CMD_QDEPTH:
                begin
                    res_w    = size_rd_reg[2*SIZE_W-1:SIZE_W];
                    res_h    = size_rd_reg[SIZE_W-1:0];
                    res_mark = flag_rd_reg[0];
                    res_tex  = mask_rd_reg[COLOR_SLOTS] ? depth_rd_reg : NO_TEXTURE;
                end
                CMD_CREATE:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    // slot record and attachment memories: read on capture, write on commit
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            gen_rd_reg   <= gen_mem[rd_slot];
            flag_rd_reg  <= flag_mem[rd_slot];
            size_rd_reg  <= size_mem[rd_slot];
            mask_rd_reg  <= mask_mem[rd_slot];
            depth_rd_reg <= depth_mem[rd_slot];
            color_rd_reg <= color_mem[{rd_slot, cs_addr}];
        end
        if (ctl.commit)
        begin
            if (gen_we)
            begin
                gen_mem[slot_reg] <= gen_wd;
            end
            if (flag_we)
            begin
                flag_mem[slot_reg] <= flag_wd;
            end
            if (size_we)
            begin
                size_mem[slot_reg] <= {nw_reg, nh_reg};
            end
            if (mask_we)
            begin
                mask_mem[slot_reg] <= mask_wd;
            end
            if (depth_we)
            begin
                depth_mem[slot_reg] <= tex_reg;
            end
            if (color_we)
            begin
                color_mem[{slot_reg, CS_W'(cs_reg)}] <= tex_reg;
            end
        end
    end

    // free queue: head entry is read every cycle, with write-through
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            fq_mem[tail] <= slot_reg;
        end
        if (push_ok && (tail == head_next))
        begin
            q_head_reg <= slot_reg;
        end
        else
        begin
            q_head_reg <= fq_mem[head_next];
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg        <= cmd_t'(cmd);
            idx_reg        <= handle_index;
            hgen_reg       <= handle_gen;
            nw_reg         <= new_width;
            nh_reg         <= new_height;
            cs_reg         <= color_slot;
            tex_reg        <= texture_word;
            slot_reg       <= rd_slot;
            fresh_pick_reg <= !from_queue;
            full_reg       <= !from_queue && !fresh_avail;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            status_reg        <= res_status;
            out_index_reg     <= res_idx;
            out_gen_reg       <= res_gen;
            out_width_reg     <= res_w;
            out_height_reg    <= res_h;
            needs_rebuild_reg <= res_mark;
            out_texture_reg   <= res_tex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            fill_reg        <= '0;
            fresh_count_reg <= '0;
        end
        else
        begin
            head_reg        <= head_next;
            fill_reg        <= fill_next;
            fresh_count_reg <= fresh_count_next;
        end
    end

    assign status        = status_reg;
    assign out_index     = out_index_reg;
    assign out_gen       = out_gen_reg;
    assign out_width     = out_width_reg;
    assign out_height    = out_height_reg;
    assign needs_rebuild = needs_rebuild_reg;
    assign out_texture   = out_texture_reg;

`ifndef NO_ASSERTIONS
    // queued free slots are always slots that have been handed out before
    a_fill_le_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= fresh_count_reg)
        else $error("free queue holds more slots than were ever used");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit && pop) |-> (fill_reg != '0))
        else $error("pop from empty free queue");

    a_fresh_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fresh_count_reg != $past(fresh_count_reg))
            |-> (fresh_count_reg == $past(fresh_count_reg) + 1'b1))
        else $error("fresh slot count moved by other than one");
`endif

endmodule

FILE: hw/rtl/generational_handle_table.sv
// A request is latched as it is accepted in idle; its result and result valid are registered
// at the commit in the execute state. Each request reads its slot record from the synchronous
// record memories on capture and writes it back on commit; no new request is taken until that commit.
// A waiting result does not block acceptance; a full result register stalls commit.
// Reset: asynchronous, immediate; no clearing pass, the fresh-slot count guards
// records that have never been written.
module generational_handle_table
    import ght_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int COLOR_SLOTS = COLOR_SLOTS_DEF,
    parameter int GEN_BITS    = GEN_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [IDX_PORT_W-1:0] handle_index,
    input  logic [GEN_PORT_W-1:0] handle_gen,
    input  logic [SIZE_W-1:0]     new_width,
    input  logic [SIZE_W-1:0]     new_height,
    input  logic [CSEL_W-1:0]     color_slot,
    input  logic [TEX_W-1:0]      texture_word,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [IDX_PORT_W-1:0] out_index,
    output logic [GEN_PORT_W-1:0] out_gen,
    output logic [SIZE_W-1:0]     out_width,
    output logic [SIZE_W-1:0]     out_height,
    output logic                  needs_rebuild,
    output logic [TEX_W-1:0]      out_texture
);

    // The controller takes a request in idle, latching it and issuing the
    // record reads; in the execute state, once the result register can take a new
    // result, the datapath checks the handle, writes the record back and loads the result register.
    ght_ctl_t ctl;

    ght_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ctl       (ctl)
    );

    // Datapath holds the per-slot records (generation, live and dirty marks,
    // size, attachment mask), the colour and depth stores and the free queue.
    // Create prefers the oldest freed slot, then the next never-used one.
    ght_datapath #(
        .SLOTS       (SLOTS),
        .COLOR_SLOTS (COLOR_SLOTS),
        .GEN_BITS    (GEN_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .cmd           (cmd),
        .handle_index  (handle_index),
        .handle_gen    (handle_gen),
        .new_width     (new_width),
        .new_height    (new_height),
        .color_slot    (color_slot),
        .texture_word  (texture_word),
        .status        (status),
        .out_index     (out_index),
        .out_gen       (out_gen),
        .out_width     (out_width),
        .out_height    (out_height),
        .needs_rebuild (needs_rebuild),
        .out_texture   (out_texture)
    );

endmodule
